/* design/rtp_pkg.sv */
package rtp_pkg;

	// Fixed formats of the ports
	localparam int WORD_BITS        = 32;
	localparam int FRAC_BITS        = 16;
	localparam int CORDIC_STEPS_DEF = 20;

	// Fixed-point constants, Q30 unless noted
	localparam logic signed [34:0] ONE30    = 35'sd1073741824;
	localparam logic signed [34:0] PI30     = 35'sd3373259426;
	localparam logic signed [34:0] HALFPI30 = 35'sd1686629713;
	localparam logic signed [34:0] TWOPI30  = 35'sd6746518852;
	localparam logic signed [33:0] K30      = 34'sd652032874;
	localparam logic [63:0]        TWOPI60  = 64'd7244019458077122842;
	localparam logic [63:0]        C60      = 64'd1 << (60 - FRAC_BITS);
	localparam logic signed [31:0] ONE_OUT  = 32'sd1 << FRAC_BITS;

	// Multiples of 2*pi (Q60) for the final correction of the reduction
	localparam logic [66:0] RED_M1 = {3'd0, TWOPI60};
	localparam logic [66:0] RED_M2 = RED_M1 * 67'd2;
	localparam logic [66:0] RED_M3 = RED_M1 * 67'd3;
	localparam logic [66:0] RED_M4 = RED_M1 * 67'd4;

	// Weight of amount bit i in the Q60 angle: 2^(60-FRAC_BITS+i) mod 2*pi
	function automatic logic [35:0][63:0] red_weights();
		logic [35:0][63:0] w;
		logic [63:0]       r;
		r = C60;
		for (int i = 0; i < 36; i++) begin
			w[i] = r;
			r = r << 1;
			if (r >= TWOPI60) r = r - TWOPI60;
		end
		return w;
	endfunction

	localparam logic [35:0][63:0] RED_W = red_weights();

	// Result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_DZERO = 2'd1;
	localparam logic [1:0] ST_OVF   = 2'd2;

	typedef struct packed {
		logic signed [31:0] obj_x;
		logic signed [31:0] obj_y;
		logic signed [31:0] obj_z;
		logic signed [31:0] tgt_x;
		logic signed [31:0] tgt_y;
		logic signed [31:0] tgt_z;
		logic signed [31:0] dir_i;
		logic signed [31:0] dir_j;
		logic signed [31:0] dir_k;
		logic               rotate;
	} in_t;

	typedef struct packed {
		logic [1:0]         row;
		logic signed [31:0] m_col0;
		logic signed [31:0] m_col1;
		logic signed [31:0] m_col2;
		logic signed [31:0] m_shift;
		logic [1:0]         status;
		logic               last;
	} out_t;

	// Classified item handed from front to back
	typedef struct packed {
		logic [2:0][31:0] obj;
		logic [2:0][31:0] dir;
		logic [2:0][32:0] df;
		logic             rot;
		logic             dzero;
	} job_t;

	// atan(2^-i) in Q30
	function automatic logic [34:0] atan_q30(input logic [5:0] i);
		logic [34:0] v;
		case (i)
			6'd0:    v = 35'd843314857;
			6'd1:    v = 35'd497837829;
			6'd2:    v = 35'd263043837;
			6'd3:    v = 35'd133525159;
			6'd4:    v = 35'd67021687;
			6'd5:    v = 35'd33543516;
			6'd6:    v = 35'd16775851;
			6'd7:    v = 35'd8388437;
			6'd8:    v = 35'd4194283;
			6'd9:    v = 35'd2097149;
			6'd10:   v = 35'd1048576;
			default: v = (i <= 6'd30) ? (35'd1 << (6'd30 - i)) : 35'd0;
		endcase
		return v;
	endfunction

	// Round half away from zero, drop 30 fraction bits
	function automatic logic signed [73:0] rnd30(input logic signed [73:0] v);
		logic [73:0] m;
		m = v[73] ? 74'(-v) : 74'(v);
		m = (m + (74'd1 << 29)) >> 30;
		return v[73] ? -$signed(m) : $signed(m);
	endfunction

	// Round half away from zero, Q30 to output fraction
	function automatic logic signed [34:0] rnd_out(input logic signed [34:0] v);
		logic [34:0] m;
		m = v[34] ? 35'(-v) : 35'(v);
		m = (m + (35'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
		return v[34] ? -$signed(m) : $signed(m);
	endfunction

	// Saturate to the output word; top bit flags saturation
	function automatic logic [32:0] sat_word(input logic signed [47:0] v);
		logic [32:0] r;
		if (v > 48'sd2147483647)
			r = {1'b1, 32'h7fffffff};
		else if (v < -48'sd2147483648)
			r = {1'b1, 32'h80000000};
		else
			r = {1'b0, v[31:0]};
		return r;
	endfunction

endpackage

/* design/rigid_transform_from_point_pair.sv */
// The back end takes one item per run, and only from its idle state; the bit-serial
// square roots, the three-lane divider, and in rotate mode the angle reduction and the
// CORDIC_STEPS rotations set the length of a run, which is shortest for a zero direction.
// Rows of an item leave one per cycle while res_ready is high; the front and a 2-entry
// queue take items meanwhile.
// Reset (arst_n, asynchronous, active low) empties the queue and the result buffer.
module rigid_transform_from_point_pair #(
	parameter int CORDIC_STEPS = rtp_pkg::CORDIC_STEPS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         item_valid,
	output logic         item_ready,
	input  rtp_pkg::in_t item,
	output logic         res_valid,
	input  logic         res_ready,
	output rtp_pkg::out_t res
);
	import rtp_pkg::*;

	logic push;
	logic q_ready;
	logic q_valid;
	logic pop;
	job_t wr_job;
	job_t rd_job;

	rtp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.push       (push),
		.q_ready    (q_ready),
		.job        (wr_job)
	);

	rtp_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.q_ready (q_ready),
		.wr_job  (wr_job),
		.q_valid (q_valid),
		.pop     (pop),
		.rd_job  (rd_job)
	);

	rtp_back #(
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (q_valid),
		.job_pop   (pop),
		.job       (rd_job),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

endmodule

/* design/rtp_front.sv */
module rtp_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	output logic          item_ready,
	input  rtp_pkg::in_t  item,
	output logic          push,
	input  logic          q_ready,
	output rtp_pkg::job_t job
);
	import rtp_pkg::*;

	logic  v_s1;
	job_t  job_s1;
	job_t  job_d;

	// Classify: offset between points, zero direction check
	always_comb begin
		job_d.obj   = {item.obj_z, item.obj_y, item.obj_x};
		job_d.dir   = {item.dir_k, item.dir_j, item.dir_i};
		job_d.df[0] = 33'(item.tgt_x) - 33'(item.obj_x);
		job_d.df[1] = 33'(item.tgt_y) - 33'(item.obj_y);
		job_d.df[2] = 33'(item.tgt_z) - 33'(item.obj_z);
		job_d.rot   = item.rotate;
		job_d.dzero = (item.dir_i == 32'sd0) && (item.dir_j == 32'sd0) &&
			(item.dir_k == 32'sd0);
	end

	assign item_ready = !v_s1 || q_ready;
	assign push       = v_s1;
	assign job        = job_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (item_valid && item_ready) begin
			v_s1 <= 1'b1;
		end else if (q_ready) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			job_s1 <= job_d;
		end
	end

endmodule

/* design/rtp_queue.sv */
module rtp_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          q_ready,
	input  rtp_pkg::job_t wr_job,
	output logic          q_valid,
	input  logic          pop,
	output rtp_pkg::job_t rd_job
);
	import rtp_pkg::*;

	job_t       mem_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign q_ready = cnt_q != 2'd2;
	assign q_valid = cnt_q != 2'd0;
	assign rd_job  = mem_q[rptr_q];
	assign do_push = push && q_ready;
	assign do_pop  = pop && q_valid;

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (do_push) wptr_q <= !wptr_q;
			if (do_pop) rptr_q <= !rptr_q;
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wr_job;
		end
	end

endmodule

/* design/rtp_back.sv */
module rtp_back #(
	parameter int CORDIC_STEPS = rtp_pkg::CORDIC_STEPS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          job_valid,
	output logic          job_pop,
	input  rtp_pkg::job_t job,
	output logic          res_valid,
	input  logic          res_ready,
	output rtp_pkg::out_t res
);
	import rtp_pkg::*;

	typedef enum logic [18:0] {
		S_IDLE = 19'h00001,
		S_NRM  = 19'h00002,
		S_SQR  = 19'h00004,
		S_SQRT = 19'h00008,
		S_SQE  = 19'h00010,
		S_DIV  = 19'h00020,
		S_KSET = 19'h00040,
		S_TSH  = 19'h00080,
		S_RED  = 19'h00100,
		S_FOLD = 19'h00200,
		S_CORD = 19'h00400,
		S_CSET = 19'h00800,
		S_RK   = 19'h01000,
		S_RM   = 19'h02000,
		S_SKW  = 19'h04000,
		S_SKA  = 19'h08000,
		S_SHM  = 19'h10000,
		S_SHF  = 19'h20000,
		S_FIN  = 19'h40000
	} state_t;

	// Control
	state_t     state_q;
	logic [5:0] cnt_q;
	logic       pass_q;
	logic [1:0] ri_q;
	logic [1:0] rj_q;
	logic       ovalid_q;
	logic [1:0] orow_q;

	// Datapath
	job_t               job_q;
	logic [29:0]        amag_q [3];
	logic               asgn_q [3];
	logic signed [6:0]  e_q;
	logic [61:0]        sum_q;
	logic [63:0]        n_q;
	logic [63:0]        r_q;
	logic [30:0]        len_q;
	logic [60:0]        num_q [3];
	logic [30:0]        rem_q [3];
	logic [32:0]        quo_q [3];
	logic signed [33:0] k_q [3];
	logic [35:0]        amount_q;
	logic [63:0]        red_q;
	logic signed [34:0] th_q;
	logic               flip_q;
	logic signed [33:0] x_q;
	logic signed [33:0] y_q;
	logic signed [34:0] cs_q;
	logic signed [34:0] sn_q;
	logic signed [34:0] oc_q;
	logic signed [34:0] tmp_q;
	logic signed [34:0] rm_q [3][3];
	logic signed [34:0] sk_q [3];
	logic signed [71:0] acc_q;
	logic signed [47:0] sh_q [3];
	logic signed [31:0] ob_m_q [3][3];
	logic signed [31:0] ob_s_q [3];
	logic [1:0]         ob_st_q;

	logic [1:0] c2;
	assign c2 = cnt_q[1:0];

	// Block scaling of the selected vector
	logic signed [33:0] nv [3];
	logic [33:0]        nm [3];
	logic [33:0]        nmax;
	logic [5:0]         npos;
	logic signed [6:0]  ne;
	logic [6:0]         nsl;
	logic [63:0]        nsh [3];
	logic               nzero;

	always_comb begin
		nmax = '0;
		npos = '0;
		for (int i = 0; i < 3; i++) begin
			nv[i] = pass_q ? 34'($signed(job_q.df[i])) : 34'($signed(job_q.dir[i]));
			nm[i] = nv[i][33] ? 34'(-nv[i]) : 34'(nv[i]);
			if (nm[i] > nmax) nmax = nm[i];
		end
		for (int b = 0; b < 34; b++) begin
			if (nmax[b]) npos = 6'(b);
		end
		ne    = $signed({1'b0, npos}) - 7'sd29;
		nsl   = 7'(-ne);
		nzero = nmax == 34'd0;
		for (int i = 0; i < 3; i++) begin
			if (!ne[6])
				nsh[i] = {30'd0, nm[i]} >> ne[5:0];
			else
				nsh[i] = {30'd0, nm[i]} << nsl[5:0];
		end
	end

	// Shared multiplier, one product per cycle
	logic signed [36:0] ma;
	logic signed [36:0] mb;
	logic signed [73:0] mp;
	logic signed [73:0] mr;

	always_comb begin
		ma = '0;
		mb = '0;
		case (state_q)
			S_SQR: begin
				ma = $signed({7'd0, amag_q[c2]});
				mb = $signed({7'd0, amag_q[c2]});
			end
			S_TSH: begin
				ma = 37'(k_q[c2]);
				mb = $signed({1'b0, amount_q});
			end
			S_RK: begin
				ma = 37'(k_q[ri_q]);
				mb = 37'(k_q[rj_q]);
			end
			S_RM: begin
				ma = 37'(tmp_q);
				mb = 37'(oc_q);
			end
			S_SKW: begin
				ma = 37'(k_q[c2]);
				mb = 37'(sn_q);
			end
			S_SHM: begin
				ma = 37'(rm_q[ri_q][rj_q]);
				mb = 37'($signed(job_q.obj[rj_q]));
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
		mp = ma * mb;
		mr = rnd30(mp);
	end

	// Square root step
	logic [5:0]  sq_sh;
	logic [63:0] sq_bit;
	logic [63:0] sq_t;
	assign sq_sh  = 6'd62 - {cnt_q[4:0], 1'b0};
	assign sq_bit = 64'd1 << sq_sh;
	assign sq_t   = r_q + sq_bit;

	// Angle reduction: four weighted amount bits per cycle, kept below 2*pi
	logic [5:0]  rd_base;
	logic [3:0]  rd_nib;
	logic [66:0] rd_sum;
	logic [63:0] rd_c;
	always_comb begin
		rd_base = {cnt_q[3:0], 2'b00};
		rd_nib  = amount_q[rd_base +: 4];
		rd_sum  = (cnt_q == 6'd0) ? 67'd0 : {3'd0, red_q};
		for (int b = 0; b < 4; b++) begin
			if (rd_nib[b]) rd_sum = rd_sum + {3'd0, RED_W[rd_base + 6'(b)]};
		end
		if (rd_sum >= RED_M4)
			rd_c = 64'(rd_sum - RED_M4);
		else if (rd_sum >= RED_M3)
			rd_c = 64'(rd_sum - RED_M3);
		else if (rd_sum >= RED_M2)
			rd_c = 64'(rd_sum - RED_M2);
		else if (rd_sum >= RED_M1)
			rd_c = 64'(rd_sum - RED_M1);
		else
			rd_c = rd_sum[63:0];
	end

	// Fold into [-pi/2, pi/2]
	logic signed [34:0] fo_th;
	logic signed [34:0] fo_out;
	logic               fo_flip;
	always_comb begin
		fo_th   = $signed({2'b00, red_q[62:30]});
		fo_flip = 1'b0;
		if (fo_th > PI30) fo_th = fo_th - TWOPI30;
		fo_out = fo_th;
		if (fo_th > HALFPI30) begin
			fo_out  = fo_th - PI30;
			fo_flip = 1'b1;
		end else if (fo_th < -HALFPI30) begin
			fo_out  = fo_th + PI30;
			fo_flip = 1'b1;
		end
	end

	// Amount from the scaled length
	logic [6:0]  am_s;
	logic [63:0] am_v;
	always_comb begin
		am_s = 7'(-e_q);
		if (!e_q[6])
			am_v = r_q << e_q[2:0];
		else
			am_v = (r_q + (64'd1 << (am_s[5:0] - 6'd1))) >> am_s[5:0];
	end

	// Output rounding, saturation and status
	logic [32:0] fm [3][3];
	logic [32:0] fs [3];
	logic        f_ovf;
	logic [1:0]  f_st;
	always_comb begin
		f_ovf = 1'b0;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				fm[i][j] = sat_word(48'(rnd_out(rm_q[i][j])));
				f_ovf    = f_ovf | fm[i][j][32];
			end
			fs[i] = sat_word(sh_q[i]);
			f_ovf = f_ovf | fs[i][32];
		end
		if (job_q.dzero)
			f_st = ST_DZERO;
		else if (f_ovf)
			f_st = ST_OVF;
		else
			f_st = ST_OK;
	end

	assign job_pop   = (state_q == S_IDLE) && job_valid;
	assign res_valid = ovalid_q;

	always_comb begin
		res.row     = orow_q;
		res.m_col0  = ob_m_q[orow_q][0];
		res.m_col1  = ob_m_q[orow_q][1];
		res.m_col2  = ob_m_q[orow_q][2];
		res.m_shift = ob_s_q[orow_q];
		res.status  = ob_st_q;
		res.last    = orow_q == 2'd2;
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			pass_q   <= 1'b0;
			ri_q     <= '0;
			rj_q     <= '0;
			ovalid_q <= 1'b0;
			orow_q   <= '0;
		end else begin
			if (res_valid && res_ready) begin
				if (orow_q == 2'd2) ovalid_q <= 1'b0;
				else orow_q <= orow_q + 2'd1;
			end
			case (state_q)
				S_IDLE: begin
					if (job_valid) begin
						pass_q  <= 1'b0;
						state_q <= job.dzero ? S_FIN : S_NRM;
					end
				end
				S_NRM: begin
					cnt_q <= '0;
					if (pass_q && nzero)
						state_q <= job_q.rot ? S_RED : S_TSH;
					else
						state_q <= S_SQR;
				end
				S_SQR: begin
					cnt_q <= (c2 == 2'd2) ? 6'd0 : cnt_q + 6'd1;
					if (c2 == 2'd2) state_q <= S_SQRT;
				end
				S_SQRT: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd31) state_q <= S_SQE;
				end
				S_SQE: begin
					cnt_q <= '0;
					if (!pass_q) state_q <= S_DIV;
					else state_q <= job_q.rot ? S_RED : S_TSH;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd60) state_q <= S_KSET;
				end
				S_KSET: begin
					pass_q  <= 1'b1;
					state_q <= S_NRM;
				end
				S_TSH: begin
					cnt_q <= cnt_q + 6'd1;
					if (c2 == 2'd2) state_q <= S_FIN;
				end
				S_RED: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd8) state_q <= S_FOLD;
				end
				S_FOLD: begin
					cnt_q   <= '0;
					state_q <= S_CORD;
				end
				S_CORD: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'(CORDIC_STEPS - 1)) state_q <= S_CSET;
				end
				S_CSET: begin
					ri_q    <= '0;
					rj_q    <= '0;
					state_q <= S_RK;
				end
				S_RK: begin
					state_q <= S_RM;
				end
				S_RM: begin
					state_q <= S_RK;
					if (rj_q == 2'd2) begin
						rj_q <= '0;
						if (ri_q == 2'd2) begin
							cnt_q   <= '0;
							state_q <= S_SKW;
						end else begin
							ri_q <= ri_q + 2'd1;
						end
					end else begin
						rj_q <= rj_q + 2'd1;
					end
				end
				S_SKW: begin
					cnt_q <= cnt_q + 6'd1;
					if (c2 == 2'd2) state_q <= S_SKA;
				end
				S_SKA: begin
					ri_q    <= '0;
					rj_q    <= '0;
					state_q <= S_SHM;
				end
				S_SHM: begin
					if (rj_q == 2'd2) state_q <= S_SHF;
					else rj_q <= rj_q + 2'd1;
				end
				S_SHF: begin
					rj_q <= '0;
					if (ri_q == 2'd2) begin
						state_q <= S_FIN;
					end else begin
						ri_q    <= ri_q + 2'd1;
						state_q <= S_SHM;
					end
				end
				S_FIN: begin
					if (!ovalid_q) begin
						ovalid_q <= 1'b1;
						orow_q   <= '0;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (job_valid) job_q <= job;
			end
			S_NRM: begin
				for (int i = 0; i < 3; i++) begin
					amag_q[i] <= nsh[i][29:0];
					asgn_q[i] <= nv[i][33];
				end
				e_q   <= ne;
				sum_q <= '0;
				if (pass_q && nzero) amount_q <= '0;
			end
			S_SQR: begin
				sum_q <= sum_q + mp[61:0];
				n_q   <= {2'b00, sum_q + mp[61:0]};
				r_q   <= '0;
			end
			S_SQRT: begin
				if (n_q >= sq_t) begin
					n_q <= n_q - sq_t;
					r_q <= (r_q >> 1) + sq_bit;
				end else begin
					r_q <= r_q >> 1;
				end
			end
			S_SQE: begin
				if (!pass_q) begin
					len_q <= r_q[30:0];
					for (int i = 0; i < 3; i++) begin
						num_q[i] <= ({31'd0, amag_q[i]} << 30) + {30'd0, r_q[31:1]};
						rem_q[i] <= '0;
						quo_q[i] <= '0;
					end
				end else begin
					amount_q <= am_v[35:0];
				end
			end
			S_DIV: begin
				for (int i = 0; i < 3; i++) begin
					num_q[i] <= {num_q[i][59:0], 1'b0};
					if ({rem_q[i], num_q[i][60]} >= {1'b0, len_q}) begin
						rem_q[i] <= 31'({rem_q[i], num_q[i][60]} - {1'b0, len_q});
						quo_q[i] <= {quo_q[i][31:0], 1'b1};
					end else begin
						rem_q[i] <= {rem_q[i][29:0], num_q[i][60]};
						quo_q[i] <= {quo_q[i][31:0], 1'b0};
					end
				end
			end
			S_KSET: begin
				for (int i = 0; i < 3; i++) begin
					k_q[i] <= asgn_q[i] ? -$signed({1'b0, quo_q[i]}) : $signed({1'b0, quo_q[i]});
				end
			end
			S_TSH: begin
				sh_q[c2] <= mr[47:0];
				for (int i = 0; i < 3; i++) begin
					for (int j = 0; j < 3; j++) begin
						rm_q[i][j] <= (i == j) ? ONE30 : 35'sd0;
					end
				end
			end
			S_RED: begin
				red_q <= rd_c;
			end
			S_FOLD: begin
				th_q   <= fo_out;
				flip_q <= fo_flip;
				x_q    <= K30;
				y_q    <= '0;
			end
			S_CORD: begin
				if (!th_q[34]) begin
					x_q  <= x_q - (y_q >>> cnt_q);
					y_q  <= y_q + (x_q >>> cnt_q);
					th_q <= th_q - $signed(atan_q30(cnt_q));
				end else begin
					x_q  <= x_q + (y_q >>> cnt_q);
					y_q  <= y_q - (x_q >>> cnt_q);
					th_q <= th_q + $signed(atan_q30(cnt_q));
				end
			end
			S_CSET: begin
				cs_q <= flip_q ? -35'(x_q) : 35'(x_q);
				sn_q <= flip_q ? -35'(y_q) : 35'(y_q);
				oc_q <= ONE30 - (flip_q ? -35'(x_q) : 35'(x_q));
			end
			S_RK: begin
				tmp_q <= mr[34:0];
			end
			S_RM: begin
				rm_q[ri_q][rj_q] <= mr[34:0] + ((ri_q == rj_q) ? cs_q : 35'sd0);
			end
			S_SKW: begin
				sk_q[c2] <= mr[34:0];
			end
			S_SKA: begin
				rm_q[0][1] <= rm_q[0][1] - sk_q[2];
				rm_q[1][0] <= rm_q[1][0] + sk_q[2];
				rm_q[0][2] <= rm_q[0][2] + sk_q[1];
				rm_q[2][0] <= rm_q[2][0] - sk_q[1];
				rm_q[1][2] <= rm_q[1][2] - sk_q[0];
				rm_q[2][1] <= rm_q[2][1] + sk_q[0];
			end
			S_SHM: begin
				acc_q <= ((rj_q == 2'd0) ? 72'sd0 : acc_q) + mp[71:0];
			end
			S_SHF: begin
				sh_q[ri_q] <= 48'($signed(job_q.obj[ri_q])) - 48'(rnd30(74'(acc_q)));
			end
			S_FIN: begin
				if (!ovalid_q) begin
					ob_st_q <= f_st;
					for (int i = 0; i < 3; i++) begin
						for (int j = 0; j < 3; j++) begin
							if (f_st != ST_OK)
								ob_m_q[i][j] <= (i == j) ? ONE_OUT : 32'sd0;
							else
								ob_m_q[i][j] <= $signed(fm[i][j][31:0]);
						end
						ob_s_q[i] <= (f_st != ST_OK) ? 32'sd0 : $signed(fs[i][31:0]);
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Row index stays inside the matrix while a result is offered
	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		ovalid_q |-> orow_q != 2'd3)
		else $error("row index out of range");

	// Result buffer is never reloaded while rows are pending
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && ovalid_q) |=> state_q == S_FIN)
		else $error("result buffer reload while busy");

	// Last row transfer frees the result buffer
	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_ready && orow_q == 2'd2) |=> !ovalid_q)
		else $error("result buffer not freed after last row");

	// Scaled axis length lies in the normalized range
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SQE && !pass_q) |-> (r_q >= 64'd536870912 && r_q < 64'd2147483648))
		else $error("axis length outside normalized range");

endmodule

/* sim/tb_rigid_transform_from_point_pair.sv */
`timescale 1ns / 1ps

module tb_rigid_transform_from_point_pair;
	import rtp_pkg::*;

	localparam longint LIMIT_CYCLES = 1500000;

	// Q30 angle and scaling constants, and 2*pi in Q60
	localparam longint Q_ONE30  = 64'sd1073741824;
	localparam longint Q_PI30   = 64'sd3373259426;
	localparam longint Q_HPI30  = 64'sd1686629713;
	localparam longint Q_2PI30  = 64'sd6746518852;
	localparam longint Q_K30    = 64'sd652032874;
	localparam logic [63:0] Q_2PI60 = 64'd7244019458077122842;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	in_t item = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	out_t res;

	in_t pending_items[$];
	out_t expected_rows[$];
	int errors = 0;
	longint cycles = 0;
	int item_idle_pct = 0;
	int res_idle_pct = 0;
	bit hold_items = 1'b0;

	rigid_transform_from_point_pair uut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.res_valid(res_valid), .res_ready(res_ready), .res(res)
	);

	always #5 clk = ~clk;

	// Arithmetic helpers
	function automatic longint absval(input longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic longint round_shift(input longint v, input int s);
		longint m;
		if (s <= 0) return v;
		m = (absval(v) + (64'sd1 <<< (s - 1))) >>> s;
		return v < 0 ? -m : m;
	endfunction

	function automatic longint floor_shift(input longint v, input int s);
		return v >>> s;
	endfunction

	function automatic longint mul_q30(input longint a, input longint b);
		return round_shift(a * b, 30);
	endfunction

	function automatic longint atan_entry(input int i);
		case (i)
			0: return 843314857;
			1: return 497837829;
			2: return 263043837;
			3: return 133525159;
			4: return 67021687;
			5: return 33543516;
			6: return 16775851;
			7: return 8388437;
			8: return 4194283;
			9: return 2097149;
			10: return 1048576;
			default: return (i <= 30) ? (64'sd1 <<< (30 - i)) : 0;
		endcase
	endfunction

	function automatic logic [63:0] int_sqrt(input logic [63:0] n);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// Block-scaled length; returns 0 for a zero vector
	function automatic bit block_scale(input longint v[3], output longint a[3],
			output longint len, output int ex);
		logic [63:0] m, u, sum;
		int e;
		m = 0;
		sum = 0;
		e = 0;
		for (int i = 0; i < 3; i++) if (absval(v[i]) > m) m = absval(v[i]);
		if (m == 0) begin
			len = 0;
			ex = 0;
			for (int i = 0; i < 3; i++) a[i] = 0;
			return 1'b0;
		end
		while (m >= (64'd1 << 30)) begin m = m >> 1; e++; end
		while (m < (64'd1 << 29)) begin m = m << 1; e--; end
		for (int i = 0; i < 3; i++) begin
			u = absval(v[i]);
			u = e >= 0 ? u >> e : u << (-e);
			a[i] = v[i] < 0 ? -longint'(u) : longint'(u);
			sum = sum + u * u;
		end
		len = longint'(int_sqrt(sum));
		ex = e;
		return 1'b1;
	endfunction

	function automatic longint clamp_word(input longint v, inout bit ovf);
		if (v > 64'sd2147483647) begin ovf = 1'b1; return 64'sd2147483647; end
		if (v < -64'sd2147483648) begin ovf = 1'b1; return -64'sd2147483648; end
		return v;
	endfunction

	// Predict the three rows of [R | t] for one item
	task automatic predict_transform(input in_t it);
		longint o[3], d[3], df[3], a[3], b[3], k[3], sh[3], mm[3][3], ss[3];
		longint rr[3][3];
		longint len, len2, amount, th, x, y, cs, sn, oc, dx, dy;
		logic [63:0] q, r;
		int e, e2;
		bit ovf, flip;
		logic [1:0] st;
		out_t row;
		ovf = 1'b0;
		flip = 1'b0;
		amount = 0;
		st = ST_OK;
		o[0] = it.obj_x; o[1] = it.obj_y; o[2] = it.obj_z;
		df[0] = longint'(it.tgt_x) - o[0];
		df[1] = longint'(it.tgt_y) - o[1];
		df[2] = longint'(it.tgt_z) - o[2];
		d[0] = it.dir_i; d[1] = it.dir_j; d[2] = it.dir_k;
		if (!block_scale(d, a, len, e)) begin
			st = ST_DZERO;
		end else begin
			for (int i = 0; i < 3; i++) begin
				q = ((64'(absval(a[i])) << 30) + (64'(len) >> 1)) / 64'(len);
				k[i] = a[i] < 0 ? -longint'(q) : longint'(q);
			end
			if (block_scale(df, b, len2, e2))
				amount = e2 >= 0 ? longint'(64'(len2) << e2) : round_shift(len2, -e2);
			if (!it.rotate) begin
				for (int i = 0; i < 3; i++) begin
					for (int j = 0; j < 3; j++) rr[i][j] = (i == j) ? Q_ONE30 : 0;
					sh[i] = round_shift(k[i] * amount, 30);
				end
			end else begin
				// Exact reduction modulo 2*pi in Q60
				r = 0;
				for (int i = 62; i >= 0; i--) begin
					r = r << 1;
					if (r >= Q_2PI60) r = r - Q_2PI60;
					if (amount[i]) begin
						r = r + (64'd1 << (60 - FRAC_BITS));
						if (r >= Q_2PI60) r = r - Q_2PI60;
					end
				end
				th = longint'(r >> 30);
				if (th > Q_PI30) th = th - Q_2PI30;
				if (th > Q_HPI30) begin th = th - Q_PI30; flip = 1'b1; end
				else if (th < -Q_HPI30) begin th = th + Q_PI30; flip = 1'b1; end
				x = Q_K30;
				y = 0;
				for (int i = 0; i < uut.CORDIC_STEPS; i++) begin
					dx = floor_shift(y, i);
					dy = floor_shift(x, i);
					if (th >= 0) begin x -= dx; y += dy; th -= atan_entry(i); end
					else begin x += dx; y -= dy; th += atan_entry(i); end
				end
				cs = flip ? -x : x;
				sn = flip ? -y : y;
				oc = Q_ONE30 - cs;
				for (int i = 0; i < 3; i++)
					for (int j = 0; j < 3; j++)
						rr[i][j] = mul_q30(mul_q30(k[i], k[j]), oc) + (i == j ? cs : 0);
				rr[0][1] -= mul_q30(k[2], sn); rr[1][0] += mul_q30(k[2], sn);
				rr[0][2] += mul_q30(k[1], sn); rr[2][0] -= mul_q30(k[1], sn);
				rr[1][2] -= mul_q30(k[0], sn); rr[2][1] += mul_q30(k[0], sn);
				for (int i = 0; i < 3; i++)
					sh[i] = o[i] - round_shift(rr[i][0] * o[0] + rr[i][1] * o[1]
						+ rr[i][2] * o[2], 30);
			end
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++)
					mm[i][j] = clamp_word(round_shift(rr[i][j], 30 - FRAC_BITS), ovf);
				ss[i] = clamp_word(sh[i], ovf);
			end
			if (ovf) st = ST_OVF;
		end
		if (st != ST_OK) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) mm[i][j] = (i == j) ? longint'(ONE_OUT) : 0;
				ss[i] = 0;
			end
		end
		for (int i = 0; i < 3; i++) begin
			row.row = 2'(i);
			row.m_col0 = 32'(mm[i][0]);
			row.m_col1 = 32'(mm[i][1]);
			row.m_col2 = 32'(mm[i][2]);
			row.m_shift = 32'(ss[i]);
			row.status = st;
			row.last = (i == 2);
			expected_rows.push_back(row);
		end
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint want);
		errors++;
		$display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
	endtask

	// Driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (!item_valid || item_ready) begin
				if (pending_items.size() > 0 && !hold_items
						&& $urandom_range(99) >= item_idle_pct) begin
					item <= pending_items[0];
					predict_transform(pending_items.pop_front());
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
			res_ready <= ($urandom_range(99) >= res_idle_pct);
		end
	end

	// Monitor
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && res_valid && res_ready) begin
			if (expected_rows.size() == 0) begin
				report_mismatch("unexpected transfer", 1, 0);
			end else begin
				out_t w;
				w = expected_rows.pop_front();
				if (res.row !== w.row) report_mismatch("row", res.row, w.row);
				if (res.m_col0 !== w.m_col0) report_mismatch("m_col0", res.m_col0, w.m_col0);
				if (res.m_col1 !== w.m_col1) report_mismatch("m_col1", res.m_col1, w.m_col1);
				if (res.m_col2 !== w.m_col2) report_mismatch("m_col2", res.m_col2, w.m_col2);
				if (res.m_shift !== w.m_shift)
					report_mismatch("m_shift", res.m_shift, w.m_shift);
				if (res.status !== w.status) report_mismatch("status", res.status, w.status);
				if (res.last !== w.last) report_mismatch("last", res.last, w.last);
			end
		end
		if (cycles > LIMIT_CYCLES) begin
			$display("tb_rigid_transform_from_point_pair failed");
			$finish;
		end
	end

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(3))
			0: return $urandom;
			1: return 32'($signed($urandom_range(2000000)) - 1000000);
			2: return 32'($signed($urandom_range(1 << 20)) - (1 << 19)) <<< 4;
			default: return 32'($signed($urandom_range(64)) - 32) <<< 16;
		endcase
	endfunction

	function automatic in_t rand_item();
		in_t it;
		it.obj_x = rand_coord(); it.obj_y = rand_coord(); it.obj_z = rand_coord();
		it.tgt_x = rand_coord(); it.tgt_y = rand_coord(); it.tgt_z = rand_coord();
		it.dir_i = rand_coord(); it.dir_j = rand_coord(); it.dir_k = rand_coord();
		if ($urandom_range(15) == 0) begin
			it.dir_i = 0; it.dir_j = 0; it.dir_k = 0;
		end
		it.rotate = 1'($urandom_range(1));
		return it;
	endfunction

	task automatic add_item(input logic [31:0] ox, oy, oz, tx, ty, tz, di, dj, dk,
			input logic rot);
		in_t it;
		it = {ox, oy, oz, tx, ty, tz, di, dj, dk, rot};
		pending_items.push_back(it);
	endtask

	task automatic drain_and_wait();
		while (pending_items.size() > 0 || item_valid) @(posedge clk);
		while (expected_rows.size() > 0) @(posedge clk);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: zero direction, extremes, overflow, both modes
		item_idle_pct = 25;
		res_idle_pct = 57;
		for (int m = 0; m < 2; m++) begin
			add_item(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'(m));
			add_item(32'h10000, 0, 0, 32'h30000, 0, 0, 0, 0, 32'h1, 1'(m));
			add_item(0, 0, 0, 32'h10000, 0, 0, 32'h10000, 0, 0, 1'(m));
			add_item(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff,
				32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h1, 1'(m));
			add_item(32'h7fffffff, 0, 32'h80000000, 32'h7fffffff, 0, 32'h80000000,
				32'hffffffff, 32'hffffffff, 32'hffffffff, 1'(m));
			add_item(32'h12345678, 32'hedcba987, 32'h00010000, 32'h0, 32'h0, 32'h0,
				32'h1, 32'h80000000, 32'h0, 1'(m));
			add_item(0, 0, 0, 32'h3243f, 0, 0, 0, 32'h10000, 0, 1'(m));
			add_item(32'h50000, 32'hfffb0000, 0, 32'h50000, 32'hfffb0000, 0,
				0, 0, 32'h7fffffff, 1'(m));
			add_item(32'h1000, 0, 0, 32'h7fff0000, 32'h7fff0000, 0,
				32'h10000, 32'h10000, 32'h10000, 1'(m));
		end
		add_item(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
			32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 1'b1);
		for (int i = 0; i < 80; i++) pending_items.push_back(rand_item());
		drain_and_wait();

		// Once every row is back the sender holds off, then swaps idling
		hold_items = 1'b1;
		repeat (5) @(posedge clk);
		hold_items = 1'b0;
		item_idle_pct = 57;
		res_idle_pct = 25;
		for (int i = 0; i < 85; i++) pending_items.push_back(rand_item());
		drain_and_wait();

		item_idle_pct = 0;
		res_idle_pct = 0;
		for (int i = 0; i < 85; i++) pending_items.push_back(rand_item());
		drain_and_wait();
		repeat (300) @(posedge clk);
		if (errors == 0 && expected_rows.size() == 0)
			$display("tb_rigid_transform_from_point_pair passed");
		else
			$display("tb_rigid_transform_from_point_pair failed");
		$finish;
	end
endmodule

/* rigid_transform_from_point_pair.f */
design/rtp_pkg.sv
design/rtp_front.sv
design/rtp_queue.sv
design/rtp_back.sv
design/rigid_transform_from_point_pair.sv
sim/tb_rigid_transform_from_point_pair.sv
